// ===== rtl/htc_pkg.sv =====
// Package with shared constants, types and arithmetic helpers for the transform chain.
package htc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int TRIG_ITERS_DEF = 16;
   localparam int TRIG_TABLE_LEN = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [35:0] TRIG_GAIN = 36'sd652032874;
   localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   // The spare axis code gives a pure translation.
   localparam logic [1:0] AXIS_UNUSED = 2'd3;

   // One queued transaction from the front part: the elementary transform.
   typedef struct packed {
      logic signed [31:0] sin_v;
      logic signed [31:0] cos_v;
      logic [1:0] axis;
      logic signed [31:0] tx;
      logic signed [31:0] ty;
      logic signed [31:0] tz;
      logic start;
   } elem_type;

   function automatic logic signed [35:0] atan_entry(input logic [4:0] idx);
      logic signed [35:0] r;
      case (idx)
         5'd0: r = 36'sh03243F6A8;
         5'd1: r = 36'sh01DAC6705;
         5'd2: r = 36'sh00FADBAFC;
         5'd3: r = 36'sh007F56EA6;
         5'd4: r = 36'sh003FEAB76;
         5'd5: r = 36'sh001FFD55B;
         5'd6: r = 36'sh000FFFAAA;
         5'd7: r = 36'sh0007FFF55;
         5'd8: r = 36'sh0003FFFEA;
         5'd9: r = 36'sh0001FFFFD;
         5'd10: r = 36'sh0000FFFFF;
         5'd11: r = 36'sh00007FFFF;
         5'd12: r = 36'sh00003FFFF;
         5'd13: r = 36'sh00001FFFF;
         5'd14: r = 36'sh00000FFFF;
         5'd15: r = 36'sh000007FFF;
         5'd16: r = 36'sh000003FFF;
         5'd17: r = 36'sh000001FFF;
         5'd18: r = 36'sh000000FFF;
         5'd19: r = 36'sh0000007FF;
         5'd20: r = 36'sh0000003FF;
         5'd21: r = 36'sh0000001FF;
         5'd22: r = 36'sh0000000FF;
         5'd23: r = 36'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== rtl/htc_front.sv =====
// Front part: accepts transactions and works out sine and cosine by an iterative CORDIC.
module htc_front
   import htc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int TRIG_ITERS = TRIG_ITERS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_axis,
   input  logic signed [15:0] req_angle,
   input  logic signed [31:0] req_trans_x,
   input  logic signed [31:0] req_trans_y,
   input  logic signed [31:0] req_trans_z,
   input  logic req_start_req,
   output logic q_valid,
   input  logic q_ready,
   output elem_type q_data
);
   localparam int NITER = (TRIG_ITERS < TRIG_TABLE_LEN) ? TRIG_ITERS : TRIG_TABLE_LEN;
   localparam int SH = 30 - FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ITER = 3'b010,
      ST_DONE = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [4:0] iter_ff, iter_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic neg_ff, neg_in;
   logic [1:0] axis_ff, axis_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;
   logic start_ff, start_in;
   logic signed [31:0] sin_ff, sin_in, cos_ff, cos_in;

   logic signed [35:0] z0, xr, yr, xs, ys;
   logic signed [36:0] xround, yround;

   assign req_ready = (state_ff == ST_IDLE);
   assign q_valid = (state_ff == ST_DONE);
   assign q_data = '{sin_v: sin_ff, cos_v: cos_ff, axis: axis_ff, tx: tx_ff,
                     ty: ty_ff, tz: tz_ff, start: start_ff};

   always_comb begin
      state_in = state_ff;
      iter_in = iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      neg_in = neg_ff;
      axis_in = axis_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      tz_in = tz_ff;
      start_in = start_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      z0 = 36'(req_angle) <<< 17;
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      xround = (37'(x_ff) + (37'sd1 <<< (SH - 1))) >>> SH;
      yround = (37'(y_ff) + (37'sd1 <<< (SH - 1))) >>> SH;
      xr = neg_ff ? -36'(xround) : 36'(xround);
      yr = neg_ff ? -36'(yround) : 36'(yround);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               axis_in = req_axis;
               tx_in = req_trans_x;
               ty_in = req_trans_y;
               tz_in = req_trans_z;
               start_in = req_start_req;
               x_in = TRIG_GAIN;
               y_in = '0;
               iter_in = '0;
               if (z0 > HALF_PI_Q30) begin
                  z_in = z0 - PI_Q30;
                  neg_in = 1'b1;
               end else if (z0 < -HALF_PI_Q30) begin
                  z_in = z0 + PI_Q30;
                  neg_in = 1'b1;
               end else begin
                  z_in = z0;
                  neg_in = 1'b0;
               end
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (iter_ff == 5'(NITER)) begin
               cos_in = sat32(66'(xr));
               sin_in = sat32(66'(yr));
               state_in = ST_DONE;
            end else begin
               if (z_ff >= 0) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - atan_entry(iter_ff);
               end else begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + atan_entry(iter_ff);
               end
               iter_in = iter_ff + 5'd1;
            end
         end
         ST_DONE: begin
            if (q_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      iter_ff <= iter_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      neg_ff <= neg_in;
      axis_ff <= axis_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      tz_ff <= tz_in;
      start_ff <= start_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> iter_ff <= 5'(NITER)) else $error("iteration overrun");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid && $stable(q_data)) else $error("queue word moved");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_ITER) else $error("no start");
endmodule

// ===== rtl/htc_queue.sv =====
// Short queue between the front and back parts.
module htc_queue
   import htc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  elem_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output elem_type out_data
);
   elem_type mem_ff [QUEUE_DEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("queue count");
   a_push_inc: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("queue count");
endmodule

// ===== rtl/htc_back.sv =====
// Back part: builds the elementary transform, composes or starts the chain, emits three rows.
module htc_back
   import htc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  elem_type q_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_row,
   output logic signed [31:0] rsp_elem0,
   output logic signed [31:0] rsp_elem1,
   output logic signed [31:0] rsp_elem2,
   output logic signed [31:0] rsp_elem3,
   output logic rsp_last
);
   // Each row: products into registers in ST_MUL, then sums in ST_SUM; shared over rows.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUM  = 4'b0100,
      ST_OUT  = 4'b1000
   } bstate_type;

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   bstate_type state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic signed [31:0] rot_ff [9];
   logic signed [31:0] tr_ff [3];
   logic signed [31:0] h_ff [9], h_in [9];
   logic signed [31:0] t_ff [3], t_in [3];
   logic start_ff, start_in;
   logic signed [63:0] prod_ff [12];
   logic signed [31:0] nrow [4];
   logic [3:0] rbase;

   logic signed [31:0] nsin;

   function automatic logic signed [65:0] rnd(input logic signed [63:0] p);
      return (66'(p) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   assign rbase = 4'(row_ff) * 4'd3;
   assign q_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_row = row_ff;
   assign rsp_last = (row_ff == 2'd2);
   assign rsp_elem0 = rot_ff[rbase];
   assign rsp_elem1 = rot_ff[rbase + 4'd1];
   assign rsp_elem2 = rot_ff[rbase + 4'd2];
   assign rsp_elem3 = tr_ff[row_ff];

   always_comb begin
      nsin = sat32(-66'(q_data.sin_v));
      for (int i = 0; i < 9; i++) h_in[i] = (i % 4 == 0) ? ONE : 32'sd0;
      case (q_data.axis)
         AXIS_X: begin
            h_in[4] = q_data.cos_v; h_in[5] = nsin; h_in[7] = q_data.sin_v;
            h_in[8] = q_data.cos_v;
         end
         AXIS_Y: begin
            h_in[0] = q_data.cos_v; h_in[2] = q_data.sin_v; h_in[6] = nsin;
            h_in[8] = q_data.cos_v;
         end
         AXIS_Z: begin
            h_in[0] = q_data.cos_v; h_in[1] = nsin; h_in[3] = q_data.sin_v;
            h_in[4] = q_data.cos_v;
         end
         default: ;
      endcase
      t_in[0] = q_data.tx;
      t_in[1] = q_data.ty;
      t_in[2] = q_data.tz;
      start_in = q_data.start;
      for (int c = 0; c < 3; c++)
         nrow[c] = sat32(rnd(prod_ff[c]) + rnd(prod_ff[3 + c]) + rnd(prod_ff[6 + c]));
      nrow[3] = sat32(66'(tr_ff[row_ff]) + rnd(prod_ff[9]) + rnd(prod_ff[10])
                      + rnd(prod_ff[11]));
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) begin
            state_in = ST_MUL;
            row_in = 2'd0;
         end
         ST_MUL: state_in = start_ff ? ST_OUT : ST_SUM;
         ST_SUM: state_in = (row_ff == 2'd2) ? ST_OUT : ST_MUL;
         ST_OUT: if (rsp_ready) begin
            if (row_ff == 2'd2) state_in = ST_IDLE;
            else row_in = row_ff + 2'd1;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_SUM) row_in = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
      if (state_ff == ST_MUL && start_ff) row_in = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= '0;
         for (int i = 0; i < 9; i++) rot_ff[i] <= (i % 4 == 0) ? ONE : 32'sd0;
         for (int i = 0; i < 3; i++) tr_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         if (state_ff == ST_MUL && start_ff) begin
            for (int i = 0; i < 9; i++) rot_ff[i] <= h_ff[i];
            for (int i = 0; i < 3; i++) tr_ff[i] <= t_ff[i];
         end
         if (state_ff == ST_SUM && row_ff == 2'd2) begin
            rot_ff[6] <= nrow[0];
            rot_ff[7] <= nrow[1];
            rot_ff[8] <= nrow[2];
            tr_ff[2] <= nrow[3];
         end
         if (state_ff == ST_SUM && row_ff == 2'd0) begin
            rot_ff[0] <= nrow[0]; rot_ff[1] <= nrow[1]; rot_ff[2] <= nrow[2];
            tr_ff[0] <= nrow[3];
         end
         if (state_ff == ST_SUM && row_ff == 2'd1) begin
            rot_ff[3] <= nrow[0]; rot_ff[4] <= nrow[1]; rot_ff[5] <= nrow[2];
            tr_ff[1] <= nrow[3];
         end
      end
      if (state_ff == ST_IDLE) begin
         for (int i = 0; i < 9; i++) h_ff[i] <= h_in[i];
         for (int i = 0; i < 3; i++) t_ff[i] <= t_in[i];
         start_ff <= start_in;
      end
      // Row r only reads row r of the accumulator, so in-place update is safe.
      if (state_ff == ST_MUL) begin
         for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++)
               prod_ff[3 * k + c] <= 64'(rot_ff[rbase + 4'(k)]) * 64'(h_ff[3 * k + c]);
            prod_ff[9 + k] <= 64'(rot_ff[rbase + 4'(k)]) * 64'(t_ff[k]);
         end
      end
   end

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff != 2'd3) else $error("bad row");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> state_ff == ST_IDLE) else $error("run end");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row)) else $error("row moved");
endmodule

// ===== rtl/homogeneous_transform_chain.sv =====
// Top level of the homogeneous transform chain.
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | axis, angle, trans_x/y/z, start_req
//   rsp     | out       | rsp_valid/rsp_ready  | row, elem0..elem3, last (three per item)
// The front CORDIC works on one transaction at a time; a two-entry queue decouples it.
// The back part takes an item when idle, composes each row by products then sums (a new
// chain just loads its transform), then emits one row per rsp handshake.
// Reset restores the identity transform with zero translation, synchronously.
// A stalled rsp holds the back part; the front keeps working until the queue fills.
module homogeneous_transform_chain
   import htc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int TRIG_ITERS = TRIG_ITERS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_axis,
   input  logic signed [15:0] req_angle,
   input  logic signed [31:0] req_trans_x,
   input  logic signed [31:0] req_trans_y,
   input  logic signed [31:0] req_trans_z,
   input  logic req_start_req,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_row,
   output logic signed [31:0] rsp_elem0,
   output logic signed [31:0] rsp_elem1,
   output logic signed [31:0] rsp_elem2,
   output logic signed [31:0] rsp_elem3,
   output logic rsp_last
);
   logic f_valid, f_ready, b_valid, b_ready;
   elem_type f_data, b_data;

   htc_front #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERS(TRIG_ITERS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_axis, .req_angle,
      .req_trans_x, .req_trans_y, .req_trans_z, .req_start_req,
      .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data));

   htc_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data));

   htc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_row, .rsp_elem0, .rsp_elem1, .rsp_elem2,
      .rsp_elem3, .rsp_last);
endmodule
